### rtl/core/bta_pkg.sv
// Shared types and constants for the boundary-tag heap allocator.
// Used by bta_tag_ram, bta_seq and boundary_tag_heap_allocator; depends on nothing.
package bta_pkg;

    localparam int TAG_W          = 21;
    localparam int FIELD_W        = 20;
    localparam int TYPE_W         = 2;
    localparam int TAG_BYTES      = 8;
    localparam int MIN_BLOCK      = 16;
    localparam int HEAP_BYTES_DEF = 1048576;
    localparam logic [TAG_W-1:0] LIMIT_RESET = 21'h100000;

    typedef enum logic [TYPE_W-1:0] {
        REQ_ALLOC  = 2'd0,
        REQ_FREE   = 2'd1,
        REQ_RESIZE = 2'd2,
        REQ_NOP    = 2'd3
    } req_t;

    typedef struct packed {
        logic               status;
        logic [FIELD_W-1:0] result_addr;
        logic [FIELD_W-1:0] move_from;
        logic [FIELD_W-1:0] move_len;
    } res_t;

endpackage

### rtl/core/bta_tag_ram.sv
// Tag store: one boundary tag per 8-byte heap word, one write and one read port.
// The read data is registered, so it appears in the cycle after the address.
module bta_tag_ram #(
    parameter int DEPTH = bta_pkg::HEAP_BYTES_DEF / 8,
    parameter int WIDX  = $clog2(bta_pkg::HEAP_BYTES_DEF / 8)
) (
    input  logic                      aclk,
    input  logic                      rd_en,
    input  logic [WIDX-1:0]           rd_addr,
    output logic [bta_pkg::TAG_W-1:0] rd_data,
    input  logic                      wr_en,
    input  logic [WIDX-1:0]           wr_addr,
    input  logic [bta_pkg::TAG_W-1:0] wr_data
);

    logic [bta_pkg::TAG_W-1:0] mem [DEPTH];
    logic [bta_pkg::TAG_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/bta_seq.sv
// Allocator sequencer: walks, merges, splits and writes block tags in the tag store.
// Depends on bta_pkg; drives the ports of bta_tag_ram.
module bta_seq #(
    parameter int HEAP_BYTES = bta_pkg::HEAP_BYTES_DEF,
    parameter int BW         = 23,
    parameter int WIDX       = $clog2(bta_pkg::HEAP_BYTES_DEF / 8)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [bta_pkg::TYPE_W-1:0]    req_type,
    input  logic [bta_pkg::FIELD_W-1:0]   req_size,
    input  logic [bta_pkg::FIELD_W-1:0]   req_addr,
    input  logic [bta_pkg::TAG_W-1:0]     heap_limit,
    output logic                          idle,
    output logic                          res_valid,
    input  logic                          res_ready,
    output bta_pkg::res_t                 res,
    output logic                          rd_en,
    output logic [WIDX-1:0]               rd_addr,
    input  logic [bta_pkg::TAG_W-1:0]     rd_data,
    output logic                          wr_en,
    output logic [WIDX-1:0]               wr_addr,
    output logic [bta_pkg::TAG_W-1:0]     wr_data
);

    typedef enum logic [4:0] {
        S_IDLE, S_FINISH, S_A0_END,
        S_FD_START, S_FD_CHK, S_FD_DAT,
        S_FR_START, S_FR_FOUND, S_FR_MR, S_FR_LEFT,
        S_MR_CHK, S_MR_DAT, S_MR_PUT,
        S_PUT0, S_PUT1,
        S_CV, S_CV2,
        S_AL_START, S_AL_CHK, S_AL_DAT, S_AL_GROW, S_AL_OK,
        S_RZ_FOUND, S_RZ_MERGED, S_RZ_INPLACE, S_RZ_LEFT, S_RZ_ALLOCED
    } state_t;

    localparam int FW = bta_pkg::FIELD_W;
    localparam logic [BW-1:0] TAGB = BW'(bta_pkg::TAG_BYTES);
    localparam logic [BW-1:0] MINB = BW'(bta_pkg::MIN_BLOCK);
    localparam logic [BW-1:0] HEAPB = BW'(HEAP_BYTES);

    state_t state_reg;
    state_t find_ret_reg, mr_ret_reg, put_ret_reg, carve_ret_reg, al_ret_reg, free_ret_reg;

    logic [BW-1:0] op_h_reg, op_need_reg, brk_reg, wk_b_reg, wk_rs_reg, mr_s_reg;
    logic [BW-1:0] pb_h_reg, pb_s_reg, cv_h_reg, cv_have_reg, al_hdr_reg;
    logic [FW-1:0] op_addr_reg, rz_copy_reg;
    logic [bta_pkg::TAG_W-1:0] fd_tag_reg;
    logic fd_ok_reg, mr_a_reg, pb_a_reg, cv_strict_reg, al_ok_reg;
    bta_pkg::res_t res_reg;

    logic [BW-1:0] req_addr_x, req_sum, req_need, rd_size, fd_size, mr_n, lim;
    logic [BW-1:0] cv_rest, left_sum, pb_foot, ext_limit;
    logic rd_alloc, wk_ok, mr_ok, cv_split;

    always_comb begin
        req_addr_x = {{(BW-FW){1'b0}}, req_addr};
        req_sum    = {{(BW-FW){1'b0}}, req_size} + BW'(2 * bta_pkg::TAG_BYTES + 7);
        req_need   = {req_sum[BW-1:3], 3'b000};
        rd_size    = {{(BW-bta_pkg::TAG_W){1'b0}}, rd_data[bta_pkg::TAG_W-1:3], 3'b000};
        rd_alloc   = rd_data[0];
        fd_size    = {{(BW-bta_pkg::TAG_W){1'b0}}, fd_tag_reg[bta_pkg::TAG_W-1:3], 3'b000};
        mr_n       = op_h_reg + mr_s_reg;
        wk_ok      = (rd_size >= MINB) && (rd_size <= brk_reg - wk_b_reg);
        mr_ok      = (rd_size >= MINB) && (rd_size <= brk_reg - mr_n);
        ext_limit  = {{(BW-bta_pkg::TAG_W){1'b0}}, heap_limit};
        lim        = (ext_limit < HEAPB) ? ext_limit : HEAPB;
        cv_rest    = cv_have_reg - op_need_reg;
        cv_split   = cv_strict_reg ? (cv_rest > MINB) : (cv_rest >= MINB);
        left_sum   = (op_h_reg - wk_rs_reg) + mr_s_reg;
        pb_foot    = pb_h_reg + pb_s_reg - TAGB;
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = wk_b_reg[WIDX+2:3];
        wr_en   = 1'b0;
        wr_addr = pb_h_reg[WIDX+2:3];
        wr_data = {pb_s_reg[bta_pkg::TAG_W-1:3], 2'b00, pb_a_reg};
        case (state_reg)
            S_FD_CHK, S_AL_CHK: begin
                rd_en = wk_b_reg < brk_reg;
            end
            S_MR_CHK: begin
                rd_en   = mr_n < brk_reg;
                rd_addr = mr_n[WIDX+2:3];
            end
            S_PUT0: begin
                wr_en = 1'b1;
            end
            S_PUT1: begin
                wr_en   = 1'b1;
                wr_addr = pb_foot[WIDX+2:3];
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            brk_reg   <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        op_h_reg    <= req_addr_x - TAGB;
                        op_addr_reg <= req_addr;
                        op_need_reg <= req_need;
                        res_reg     <= '0;
                        if (req_type == bta_pkg::REQ_ALLOC) begin
                            al_ret_reg <= S_A0_END;
                            state_reg  <= S_AL_START;
                        end else if (req_type == bta_pkg::REQ_FREE) begin
                            free_ret_reg <= S_FINISH;
                            state_reg    <= (req_addr_x >= TAGB) ? S_FR_START : S_FINISH;
                        end else if (req_type == bta_pkg::REQ_RESIZE) begin
                            if (req_addr_x < TAGB) begin
                                res_reg.status <= 1'b1;
                                state_reg      <= S_FINISH;
                            end else begin
                                find_ret_reg <= S_RZ_FOUND;
                                state_reg    <= S_FD_START;
                            end
                        end else begin
                            state_reg <= S_FINISH;
                        end
                    end
                end
                S_FINISH: begin
                    if (res_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_A0_END: begin
                    if (al_ok_reg) begin
                        res_reg.result_addr <= FW'(al_hdr_reg + TAGB);
                    end else begin
                        res_reg.status <= 1'b1;
                    end
                    state_reg <= S_FINISH;
                end
                S_FD_START: begin
                    wk_b_reg  <= '0;
                    wk_rs_reg <= '0;
                    state_reg <= S_FD_CHK;
                end
                S_FD_CHK: begin
                    if (wk_b_reg < brk_reg) begin
                        state_reg <= S_FD_DAT;
                    end else begin
                        fd_ok_reg <= 1'b0;
                        state_reg <= find_ret_reg;
                    end
                end
                S_FD_DAT: begin
                    if (!wk_ok) begin
                        fd_ok_reg <= 1'b0;
                        state_reg <= find_ret_reg;
                    end else if (wk_b_reg == op_h_reg) begin
                        fd_ok_reg  <= rd_alloc;
                        fd_tag_reg <= rd_data;
                        state_reg  <= find_ret_reg;
                    end else begin
                        if (rd_alloc) begin
                            wk_rs_reg <= wk_b_reg + rd_size;
                        end
                        wk_b_reg  <= wk_b_reg + rd_size;
                        state_reg <= S_FD_CHK;
                    end
                end
                S_FR_START: begin
                    find_ret_reg <= S_FR_FOUND;
                    state_reg    <= S_FD_START;
                end
                S_FR_FOUND: begin
                    if (!fd_ok_reg) begin
                        state_reg <= free_ret_reg;
                    end else begin
                        pb_h_reg    <= op_h_reg;
                        pb_s_reg    <= fd_size;
                        pb_a_reg    <= 1'b0;
                        put_ret_reg <= S_FR_MR;
                        state_reg   <= S_PUT0;
                    end
                end
                S_FR_MR: begin
                    mr_s_reg   <= fd_size;
                    mr_a_reg   <= 1'b0;
                    mr_ret_reg <= S_FR_LEFT;
                    state_reg  <= S_MR_CHK;
                end
                S_FR_LEFT: begin
                    pb_h_reg    <= wk_rs_reg;
                    pb_s_reg    <= left_sum;
                    pb_a_reg    <= 1'b0;
                    put_ret_reg <= free_ret_reg;
                    state_reg   <= S_PUT0;
                end
                S_MR_CHK: begin
                    state_reg <= (mr_n < brk_reg) ? S_MR_DAT : S_MR_PUT;
                end
                S_MR_DAT: begin
                    if (mr_ok && !rd_alloc) begin
                        mr_s_reg  <= mr_s_reg + rd_size;
                        state_reg <= S_MR_CHK;
                    end else begin
                        state_reg <= S_MR_PUT;
                    end
                end
                S_MR_PUT: begin
                    pb_h_reg    <= op_h_reg;
                    pb_s_reg    <= mr_s_reg;
                    pb_a_reg    <= mr_a_reg;
                    put_ret_reg <= mr_ret_reg;
                    state_reg   <= S_PUT0;
                end
                S_PUT0: begin
                    state_reg <= S_PUT1;
                end
                S_PUT1: begin
                    state_reg <= put_ret_reg;
                end
                S_CV: begin
                    pb_h_reg  <= cv_h_reg;
                    pb_a_reg  <= 1'b1;
                    state_reg <= S_PUT0;
                    if (cv_split) begin
                        pb_s_reg    <= op_need_reg;
                        put_ret_reg <= S_CV2;
                    end else begin
                        pb_s_reg    <= cv_have_reg;
                        put_ret_reg <= carve_ret_reg;
                    end
                end
                S_CV2: begin
                    pb_h_reg    <= cv_h_reg + op_need_reg;
                    pb_s_reg    <= cv_rest;
                    pb_a_reg    <= 1'b0;
                    put_ret_reg <= carve_ret_reg;
                    state_reg   <= S_PUT0;
                end
                S_AL_START: begin
                    wk_b_reg  <= '0;
                    state_reg <= S_AL_CHK;
                end
                S_AL_CHK: begin
                    state_reg <= (wk_b_reg < brk_reg) ? S_AL_DAT : S_AL_GROW;
                end
                S_AL_DAT: begin
                    if (!wk_ok) begin
                        state_reg <= S_AL_GROW;
                    end else if (!rd_alloc && rd_size >= op_need_reg) begin
                        cv_h_reg      <= wk_b_reg;
                        cv_have_reg   <= rd_size;
                        cv_strict_reg <= 1'b1;
                        carve_ret_reg <= S_AL_OK;
                        al_hdr_reg    <= wk_b_reg;
                        state_reg     <= S_CV;
                    end else begin
                        wk_b_reg  <= wk_b_reg + rd_size;
                        state_reg <= S_AL_CHK;
                    end
                end
                S_AL_GROW: begin
                    if (lim < brk_reg || op_need_reg > lim - brk_reg) begin
                        al_ok_reg <= 1'b0;
                        state_reg <= al_ret_reg;
                    end else begin
                        al_hdr_reg  <= brk_reg;
                        brk_reg     <= brk_reg + op_need_reg;
                        pb_h_reg    <= brk_reg;
                        pb_s_reg    <= op_need_reg;
                        pb_a_reg    <= 1'b1;
                        put_ret_reg <= S_AL_OK;
                        state_reg   <= S_PUT0;
                    end
                end
                S_AL_OK: begin
                    al_ok_reg <= 1'b1;
                    state_reg <= al_ret_reg;
                end
                S_RZ_FOUND: begin
                    if (!fd_ok_reg) begin
                        res_reg.status <= 1'b1;
                        state_reg      <= S_FINISH;
                    end else begin
                        rz_copy_reg <= FW'(fd_size - MINB);
                        if (fd_size >= op_need_reg) begin
                            cv_h_reg      <= op_h_reg;
                            cv_have_reg   <= fd_size;
                            cv_strict_reg <= 1'b0;
                            carve_ret_reg <= S_RZ_INPLACE;
                            state_reg     <= S_CV;
                        end else begin
                            mr_s_reg   <= fd_size;
                            mr_a_reg   <= fd_tag_reg[0];
                            mr_ret_reg <= S_RZ_MERGED;
                            state_reg  <= S_MR_CHK;
                        end
                    end
                end
                S_RZ_MERGED: begin
                    cv_strict_reg <= 1'b0;
                    if (mr_s_reg >= op_need_reg) begin
                        cv_h_reg      <= op_h_reg;
                        cv_have_reg   <= mr_s_reg;
                        carve_ret_reg <= S_RZ_INPLACE;
                        state_reg     <= S_CV;
                    end else if (wk_rs_reg < op_h_reg && left_sum >= op_need_reg) begin
                        cv_h_reg      <= wk_rs_reg;
                        cv_have_reg   <= left_sum;
                        carve_ret_reg <= S_RZ_LEFT;
                        state_reg     <= S_CV;
                    end else begin
                        al_ret_reg <= S_RZ_ALLOCED;
                        state_reg  <= S_AL_START;
                    end
                end
                S_RZ_INPLACE: begin
                    res_reg.result_addr <= op_addr_reg;
                    state_reg           <= S_FINISH;
                end
                S_RZ_LEFT: begin
                    res_reg.result_addr <= FW'(wk_rs_reg + TAGB);
                    res_reg.move_from   <= op_addr_reg;
                    res_reg.move_len    <= rz_copy_reg;
                    state_reg           <= S_FINISH;
                end
                S_RZ_ALLOCED: begin
                    if (al_ok_reg) begin
                        res_reg.result_addr <= FW'(al_hdr_reg + TAGB);
                        res_reg.move_from   <= op_addr_reg;
                        res_reg.move_len    <= rz_copy_reg;
                        free_ret_reg        <= S_FINISH;
                        state_reg           <= S_FR_START;
                    end else begin
                        res_reg.status <= 1'b1;
                        state_reg      <= S_FINISH;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign idle      = state_reg == S_IDLE;
    assign res_valid = state_reg == S_FINISH;
    assign res       = res_reg;

endmodule

### rtl/core/boundary_tag_heap_allocator.sv
// Top level of the boundary-tag heap allocator: stream ports, limit register, output stage.
// Depends on bta_pkg, bta_tag_ram and bta_seq.
//
//   Port group   Dir   Contents
//   s_axis_*     in    request word: kind in tuser, size and payload offset in tdata
//   m_axis_*     out   result word: status in tuser, offsets and copy length in tdata
//   cfg_*        in    heap limit register write
//
// One request is worked on at a time. Each tag read goes through the single memory read
// port, and each block write puts down a header and then a footer. A request reads one
// tag per block walked, with up to three walks for a resize that moves its block, and
// writes the tags of the blocks that it changes.
// After reset the tag store needs no clearing; requests are taken at once.
// A finished result waits in the output register while the next request is accepted.
module boundary_tag_heap_allocator #(
    parameter int HEAP_BYTES = bta_pkg::HEAP_BYTES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [39:0]                 s_axis_tdata,  // req_size, req_addr
    input  logic [1:0]                  s_axis_tuser,  // req_type
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [63:0]                 m_axis_tdata,  // result_addr, move_from, move_len
    output logic                        m_axis_tuser,  // status
    input  logic                        cfg_we,
    input  logic [bta_pkg::TAG_W-1:0]   cfg_wdata
);

    localparam int HB   = $clog2(HEAP_BYTES) + 1;
    localparam int BW   = (HB > 23) ? HB : 23;
    localparam int DEPTH = HEAP_BYTES / 8;
    localparam int WIDX = $clog2(DEPTH);

    logic [bta_pkg::TAG_W-1:0] heap_limit_reg;
    logic                      m_valid_reg;
    bta_pkg::res_t             m_res_reg;

    logic            seq_idle, res_valid, res_ready;
    bta_pkg::res_t   seq_res;
    logic            rd_en, wr_en;
    logic [WIDX-1:0] rd_addr, wr_addr;
    logic [bta_pkg::TAG_W-1:0] rd_data, wr_data;

    assign s_axis_tready = seq_idle;
    assign res_ready     = !m_valid_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_limit_reg <= bta_pkg::LIMIT_RESET;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                heap_limit_reg <= cfg_wdata;
            end
            if (res_ready) begin
                m_valid_reg <= res_valid;
                if (res_valid) begin
                    m_res_reg <= seq_res;
                end
            end
        end
    end

    bta_seq #(
        .HEAP_BYTES (HEAP_BYTES),
        .BW         (BW),
        .WIDX       (WIDX)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (s_axis_tvalid && seq_idle),
        .req_type   (s_axis_tuser),
        .req_size   (s_axis_tdata[19:0]),
        .req_addr   (s_axis_tdata[39:20]),
        .heap_limit (heap_limit_reg),
        .idle       (seq_idle),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (seq_res),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    bta_tag_ram #(
        .DEPTH (DEPTH),
        .WIDX  (WIDX)
    ) u_tag_ram (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_res_reg.status;
    assign m_axis_tdata  = {4'b0000, m_res_reg.move_len, m_res_reg.move_from,
                            m_res_reg.result_addr};

endmodule

### tb/sv/tb.sv
// Self-checking testbench for boundary_tag_heap_allocator: a queue-fed stream driver, a
// monitor that checks each result word against a built-in boundary-tag heap predictor.
// Depends on bta_pkg and the allocator RTL.
`timescale 1ns / 100ps

module tb;

    localparam int WORDS = bta_pkg::HEAP_BYTES_DEF / 8;

    typedef struct packed {
        logic [1:0]  kind;
        logic [19:0] size;
        logic [19:0] addr;
    } op_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        cfg_we = 1'b0;
    logic [20:0] cfg_wdata = '0;

    boundary_tag_heap_allocator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // Predictor state: one tag per 8-byte word, the break and the limit.
    bit [20:0]   tags [WORDS];
    int unsigned brk = 0;
    int unsigned limit_reg = 1048576;

    op_t           pending_ops[$];
    bta_pkg::res_t expected_results[$];
    int unsigned   live_addrs[$];
    int            fails = 0;
    int unsigned   cycle = 0;
    int            hold_left = 0;

    function automatic int unsigned tag_rd(int unsigned b);
        return ((b >> 3) < WORDS) ? tags[b >> 3] : 0;
    endfunction

    function automatic void tag_wr(int unsigned b, int unsigned v);
        if ((b >> 3) < WORDS) tags[b >> 3] = v[20:0];
    endfunction

    function automatic int unsigned bsize(int unsigned h);
        return tag_rd(h) & ~32'h7;
    endfunction

    function automatic bit is_used(int unsigned h);
        return (tag_rd(h) & 1) != 0;
    endfunction

    function automatic void put_blk(int unsigned h, int unsigned s, bit a);
        int unsigned t;
        t = (s & ~32'h7) | a;
        tag_wr(h, t);
        tag_wr(h + s - 8, t);
    endfunction

    function automatic bit well_formed(int unsigned h);
        int unsigned s;
        s = bsize(h);
        return s >= 16 && h < brk && s <= brk - h;
    endfunction

    function automatic bit locate(int unsigned h, output int unsigned run);
        int unsigned b, rs;
        b = 0;
        rs = 0;
        run = 0;
        while (b < brk) begin
            if (!well_formed(b)) return 0;
            if (b == h) begin
                run = rs;
                return is_used(b);
            end
            if (is_used(b)) rs = b + bsize(b);
            b += bsize(b);
        end
        return 0;
    endfunction

    function automatic int unsigned absorb_right(int unsigned h);
        int unsigned s, n;
        bit a;
        s = bsize(h);
        a = is_used(h);
        n = h + s;
        while (n < brk && well_formed(n) && !is_used(n)) begin
            s += bsize(n);
            n = h + s;
        end
        put_blk(h, s, a);
        return s;
    endfunction

    function automatic void split_blk(int unsigned h, int unsigned have, int unsigned need,
                                      bit strict);
        int unsigned rest;
        rest = have - need;
        if (strict ? rest > 16 : rest >= 16) begin
            put_blk(h, need, 1'b1);
            put_blk(h + need, rest, 1'b0);
        end else begin
            put_blk(h, have, 1'b1);
        end
    endfunction

    function automatic int unsigned need_of(int unsigned size);
        return (size + 23) & ~32'h7;
    endfunction

    function automatic bit heap_alloc(int unsigned size, output int unsigned hdr);
        int unsigned need, lim, b, s;
        need = need_of(size);
        lim = limit_reg < bta_pkg::HEAP_BYTES_DEF ? limit_reg : bta_pkg::HEAP_BYTES_DEF;
        b = 0;
        hdr = 0;
        while (b < brk && well_formed(b)) begin
            s = bsize(b);
            if (!is_used(b) && s >= need) begin
                split_blk(b, s, need, 1'b1);
                hdr = b;
                return 1;
            end
            b += s;
        end
        if (lim < brk || need > lim - brk) return 0;
        b = brk;
        brk += need;
        put_blk(b, need, 1'b1);
        hdr = b;
        return 1;
    endfunction

    function automatic void heap_free(int unsigned h);
        int unsigned rs, s;
        if (!locate(h, rs)) return;
        put_blk(h, bsize(h), 1'b0);
        s = absorb_right(h);
        put_blk(rs, (h - rs) + s, 1'b0);
    endfunction

    function automatic bta_pkg::res_t heap_apply(op_t op);
        bta_pkg::res_t r;
        int unsigned size, addr, h, nh, rs, need, cur, copy;
        r = '0;
        size = op.size;
        addr = op.addr;
        h = addr - 8;
        case (op.kind)
            bta_pkg::REQ_ALLOC: begin
                if (heap_alloc(size, nh)) r.result_addr = nh + 8;
                else r.status = 1'b1;
            end
            bta_pkg::REQ_FREE: begin
                if (addr >= 8) heap_free(h);
            end
            bta_pkg::REQ_RESIZE: begin
                if (addr < 8 || !locate(h, rs)) begin
                    r.status = 1'b1;
                end else begin
                    need = need_of(size);
                    cur = bsize(h);
                    copy = cur - 16;
                    if (cur >= need) begin
                        split_blk(h, cur, need, 1'b0);
                        r.result_addr = addr;
                    end else begin
                        cur = absorb_right(h);
                        if (cur >= need) begin
                            split_blk(h, cur, need, 1'b0);
                            r.result_addr = addr;
                        end else if (rs < h && (h - rs) + cur >= need) begin
                            split_blk(rs, (h - rs) + cur, need, 1'b0);
                            r.result_addr = rs + 8;
                            r.move_from = addr;
                            r.move_len = copy;
                        end else if (heap_alloc(size, nh)) begin
                            r.result_addr = nh + 8;
                            r.move_from = addr;
                            r.move_len = copy;
                            heap_free(h);
                        end else begin
                            r.status = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic void drop_live(int unsigned a);
        foreach (live_addrs[i]) begin
            if (live_addrs[i] == a) begin
                live_addrs.delete(i);
                return;
            end
        end
    endfunction

    // Queues one request, predicts its result and keeps the list of live blocks current.
    function automatic bta_pkg::res_t issue(bta_pkg::req_t kind, int unsigned size,
                                            int unsigned addr);
        op_t           op;
        bta_pkg::res_t r;
        op.kind = kind;
        op.size = size[19:0];
        op.addr = addr[19:0];
        r = heap_apply(op);
        pending_ops.push_back(op);
        expected_results.push_back(r);
        if (kind == bta_pkg::REQ_ALLOC && !r.status) live_addrs.push_back(r.result_addr);
        if (kind == bta_pkg::REQ_FREE) drop_live(op.addr);
        if (kind == bta_pkg::REQ_RESIZE && !r.status) begin
            drop_live(op.addr);
            live_addrs.push_back(r.result_addr);
        end
        return r;
    endfunction

    function automatic int unsigned pick_addr();
        if (live_addrs.size() > 0 && $urandom_range(0, 99) < 80)
            return live_addrs[$urandom_range(0, live_addrs.size() - 1)];
        if ($urandom_range(0, 1)) return $urandom_range(0, 20'hFFFFF);
        return $urandom_range(0, brk + 64);
    endfunction

    function automatic int unsigned pick_size();
        if ($urandom_range(0, 99) < 3) return $urandom_range(0, 20'hFFFFF);
        return $urandom_range(0, 200);
    endfunction

    function automatic bit quiet_window();
        return cycle >= 3000 && cycle < 8000;
    endfunction

    always @(posedge aclk) cycle <= cycle + 1;

    // Driver.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (pending_ops.size() > 0 && (quiet_window() || $urandom_range(0, 99) >= 23)) begin
                s_axis_tdata <= {pending_ops[0].addr, pending_ops[0].size};
                s_axis_tuser <= pending_ops[0].kind;
                s_axis_tvalid <= 1'b1;
                void'(pending_ops.pop_front());
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // One long hold-off lets the block back up into its input.
    always @(posedge aclk) begin
        if (cycle == 1500) hold_left <= 400;
        else if (hold_left > 0) hold_left <= hold_left - 1;
    end

    // Monitor.
    always @(posedge aclk) begin
        bta_pkg::res_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result word");
                fails = fails + 1;
            end else begin
                want = expected_results.pop_front();
                if (m_axis_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                    fails = fails + 1;
                end
                if (m_axis_tdata[19:0] !== want.result_addr) begin
                    $error("result_addr: expected %0h, got %0h", want.result_addr,
                           m_axis_tdata[19:0]);
                    fails = fails + 1;
                end
                if (m_axis_tdata[39:20] !== want.move_from) begin
                    $error("move_from: expected %0h, got %0h", want.move_from,
                           m_axis_tdata[39:20]);
                    fails = fails + 1;
                end
                if (m_axis_tdata[59:40] !== want.move_len) begin
                    $error("move_len: expected %0h, got %0h", want.move_len,
                           m_axis_tdata[59:40]);
                    fails = fails + 1;
                end
            end
        end
        if (!aresetn || hold_left > 0 || cycle == 1500) m_axis_tready <= 1'b0;
        else m_axis_tready <= quiet_window() || $urandom_range(0, 99) >= 23;
    end

    task automatic drain();
        while (pending_ops.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic set_limit(int unsigned v);
        cfg_wdata <= v[20:0];
        cfg_we <= 1'b1;
        @(posedge aclk);
        cfg_we <= 1'b0;
        limit_reg = v & 32'h1FFFFF;
        @(posedge aclk);
    endtask

    initial begin
        int unsigned limits[5];
        int unsigned a, b, c, d;
        int roll;
        bta_pkg::res_t r;
        limits = '{65536, 16, 1048576, 4096, 1048576};
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reuse and split, all three resize paths, frees that merge, bad addresses.
        r = issue(bta_pkg::REQ_ALLOC, 24, 0);
        a = r.result_addr;
        r = issue(bta_pkg::REQ_ALLOC, 40, 0);
        b = r.result_addr;
        r = issue(bta_pkg::REQ_ALLOC, 8, 0);
        c = r.result_addr;
        r = issue(bta_pkg::REQ_ALLOC, 100, 0);
        d = r.result_addr;
        r = issue(bta_pkg::REQ_ALLOC, 0, 0);
        r = issue(bta_pkg::REQ_ALLOC, 20'hFFFFF, 0);
        r = issue(bta_pkg::REQ_FREE, 0, b);
        r = issue(bta_pkg::REQ_RESIZE, 64, c);
        c = r.result_addr;
        r = issue(bta_pkg::REQ_RESIZE, 0, d);
        r = issue(bta_pkg::REQ_FREE, 0, a);
        r = issue(bta_pkg::REQ_RESIZE, 500, d);
        d = r.result_addr;
        r = issue(bta_pkg::REQ_ALLOC, 1, 0);
        r = issue(bta_pkg::REQ_RESIZE, 60, c);
        r = issue(bta_pkg::REQ_FREE, 0, 0);
        r = issue(bta_pkg::REQ_FREE, 0, 3);
        r = issue(bta_pkg::REQ_FREE, 0, 20'hFFFFF);
        r = issue(bta_pkg::REQ_RESIZE, 10, 20'hFFFFF);
        r = issue(bta_pkg::REQ_RESIZE, 10, 4);
        r = issue(bta_pkg::REQ_NOP, 20'hFFFFF, 20'hFFFFF);
        r = issue(bta_pkg::REQ_RESIZE, 20'hFFFFF, d);
        r = issue(bta_pkg::REQ_FREE, 0, d);
        r = issue(bta_pkg::REQ_FREE, 0, d);
        r = issue(bta_pkg::REQ_ALLOC, 7, 0);
        drain();

        foreach (limits[p]) begin
            set_limit(limits[p]);
            repeat (265) begin
                roll = $urandom_range(0, 99);
                if (roll < 45) r = issue(bta_pkg::REQ_ALLOC, pick_size(), 0);
                else if (roll < 75) r = issue(bta_pkg::REQ_FREE,
                                              $urandom_range(0, 20'hFFFFF), pick_addr());
                else if (roll < 95) r = issue(bta_pkg::REQ_RESIZE, pick_size(), pick_addr());
                else r = issue(bta_pkg::REQ_NOP, $urandom_range(0, 20'hFFFFF),
                               $urandom_range(0, 20'hFFFFF));
            end
            drain();
        end

        if (fails == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #2s;
        $display("Verification failed");
        $finish;
    end
endmodule
